// File: src/knxfp_pkg.sv
// ----------------------------------------------------------------------------
// knxfp_pkg
// Shared types and constants for the telegram field parser: parse stages,
// frame descriptor, payload store write and queue status groups.
// ----------------------------------------------------------------------------
package knxfp_pkg;

  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 16;
  localparam int IDX_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int PAYLOAD_MAX = 16;
  localparam int BANKS       = 2;
  localparam int RAM_DEPTH   = PAYLOAD_MAX * BANKS;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_CTRL    = 4'd0,
    ST_SRC_HI  = 4'd1,
    ST_SRC_LO  = 4'd2,
    ST_TGT_HI  = 4'd3,
    ST_TGT_LO  = 4'd4,
    ST_INFO    = 4'd5,
    ST_PAYLOAD = 4'd6,
    ST_CHECK   = 4'd7,
    ST_END     = 4'd8
  } stage_t;

  typedef struct packed {
    logic              repeat_flag;
    logic [1:0]        priority_res;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] target_address;
    logic              group_target;
    logic [2:0]        hop_count;
    logic [IDX_W-1:0]  length;
    logic [BYTE_W-1:0] check_byte;
    logic [BYTE_W-1:0] end_byte;
    logic              bank;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } qstat_t;

endpackage

// File: src/knxfp_ram.sv
// ----------------------------------------------------------------------------
// knxfp_ram
// Generic single write port, single read port memory with registered read.
// Read data holds while read enable is low.
// ----------------------------------------------------------------------------
module knxfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/knxfp_front.sv
// ----------------------------------------------------------------------------
// knxfp_front
// Byte parser: walks the telegram stages, captures header fields, writes
// payload bytes into the current bank and hands a descriptor to the queue
// when the end byte arrives.
// ----------------------------------------------------------------------------
module knxfp_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [7:0]               rx_byte,
  input  logic                     clear_frame,
  output knxfp_pkg::ram_wr_t       ram_wr,
  output knxfp_pkg::push_t         push
);
  import knxfp_pkg::*;

  stage_t            stage_r, stage_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic              bank_r;
  logic              repeat_r;
  logic [1:0]        prio_r;
  logic [ADDR_W-1:0] src_r;
  logic [ADDR_W-1:0] tgt_r;
  logic              group_r;
  logic [2:0]        hop_r;
  logic [IDX_W-1:0]  len_r;
  logic [BYTE_W-1:0] check_r;
  logic              take;

  assign take = accept && !clear_frame;

  // next stage
  always_comb begin
    stage_nxt = stage_r;
    if (accept) begin
      if (clear_frame) begin
        stage_nxt = ST_CTRL;
      end else begin
        case (stage_r)
          ST_CTRL:    stage_nxt = ST_SRC_HI;
          ST_SRC_HI:  stage_nxt = ST_SRC_LO;
          ST_SRC_LO:  stage_nxt = ST_TGT_HI;
          ST_TGT_HI:  stage_nxt = ST_TGT_LO;
          ST_TGT_LO:  stage_nxt = ST_INFO;
          ST_INFO:    stage_nxt = ST_PAYLOAD;
          ST_PAYLOAD: stage_nxt = (idx_r == len_r) ? ST_CHECK : ST_PAYLOAD;
          ST_CHECK:   stage_nxt = ST_END;
          ST_END:     stage_nxt = ST_CTRL;
          default:    stage_nxt = ST_CTRL;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    ram_wr.we   = take && (stage_r == ST_PAYLOAD);
    ram_wr.addr = {bank_r, idx_r};
    ram_wr.data = rx_byte;

    push.valid               = take && (stage_r == ST_END);
    push.desc.repeat_flag    = repeat_r;
    push.desc.priority_res   = prio_r;
    push.desc.source_address = src_r;
    push.desc.target_address = tgt_r;
    push.desc.group_target   = group_r;
    push.desc.hop_count      = hop_r;
    push.desc.length         = len_r;
    push.desc.check_byte     = check_r;
    push.desc.end_byte       = rx_byte;
    push.desc.bank           = bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_CTRL;
      idx_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      if (take && stage_r == ST_INFO) begin
        idx_r <= '0;
      end else if (take && stage_r == ST_PAYLOAD) begin
        idx_r <= idx_r + 1'b1;
      end
      if (push.valid) begin
        bank_r <= ~bank_r;
      end
    end
  end

  // header capture
  always_ff @(posedge clk) begin
    if (take) begin
      case (stage_r)
        ST_CTRL: begin
          repeat_r <= rx_byte[5];
          prio_r   <= rx_byte[3:2];
        end
        ST_SRC_HI: src_r[15:8] <= rx_byte;
        ST_SRC_LO: src_r[7:0]  <= rx_byte;
        ST_TGT_HI: tgt_r[15:8] <= rx_byte;
        ST_TGT_LO: tgt_r[7:0]  <= rx_byte;
        ST_INFO: begin
          group_r <= rx_byte[7];
          hop_r   <= rx_byte[6:4];
          len_r   <= rx_byte[3:0];
        end
        ST_CHECK: check_r <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

// File: src/knxfp_queue.sv
// ----------------------------------------------------------------------------
// knxfp_queue
// Two-entry descriptor queue between parser and emitter. An entry stays
// until its last result has been issued, which also keeps its payload bank
// reserved.
// ----------------------------------------------------------------------------
module knxfp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  knxfp_pkg::push_t    push,
  input  logic                pop,
  output knxfp_pkg::desc_t    head,
  output knxfp_pkg::qstat_t   stat
);
  import knxfp_pkg::*;

  desc_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head          = entry_r[rd_ptr_r];
  assign stat.full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.nonempty = (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push.valid && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push.valid) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.desc;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !stat.full)
    else $error("descriptor pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> stat.nonempty)
    else $error("descriptor popped from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

// File: src/knxfp_back.sv
// ----------------------------------------------------------------------------
// knxfp_back
// Result emitter: walks the head descriptor's payload run, reads each byte
// from the payload store and drives the output register.
// ----------------------------------------------------------------------------
module knxfp_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  knxfp_pkg::desc_t             head,
  input  knxfp_pkg::qstat_t            stat,
  output logic                         pop,
  output logic                         ram_re,
  output logic [knxfp_pkg::RAM_AW-1:0] ram_raddr,
  input  logic [7:0]                   ram_rdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_repeat_flag,
  output logic [1:0]                   out_priority_res,
  output logic [15:0]                  out_source_address,
  output logic [15:0]                  out_target_address,
  output logic                         out_group_target,
  output logic [2:0]                   out_hop_count,
  output logic [4:0]                   out_payload_count,
  output logic [3:0]                   out_payload_index,
  output logic [7:0]                   out_payload_byte,
  output logic [7:0]                   out_check_byte,
  output logic [7:0]                   out_end_byte,
  output logic                         out_last
);
  import knxfp_pkg::*;

  logic [IDX_W-1:0]   k_r;
  logic               valid_r;
  logic               ready;
  logic               issue;
  logic               at_last;
  desc_t              desc_r;
  logic [IDX_W-1:0]   index_r;
  logic               last_r;

  assign ready     = !valid_r || !out_stall;
  assign issue     = ready && stat.nonempty;
  assign at_last   = (k_r == head.length);
  assign pop       = issue && at_last;
  assign ram_re    = issue;
  assign ram_raddr = {head.bank, k_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      if (issue) begin
        k_r <= at_last ? '0 : k_r + 1'b1;
      end
      if (ready) begin
        valid_r <= stat.nonempty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      desc_r  <= head;
      index_r <= k_r;
      last_r  <= at_last;
    end
  end

  assign out_valid          = valid_r;
  assign out_repeat_flag    = desc_r.repeat_flag;
  assign out_priority_res   = desc_r.priority_res;
  assign out_source_address = desc_r.source_address;
  assign out_target_address = desc_r.target_address;
  assign out_group_target   = desc_r.group_target;
  assign out_hop_count      = desc_r.hop_count;
  assign out_payload_count  = {1'b0, desc_r.length} + COUNT_W'(1);
  assign out_payload_index  = index_r;
  assign out_payload_byte   = ram_rdata;
  assign out_check_byte     = desc_r.check_byte;
  assign out_end_byte       = desc_r.end_byte;
  assign out_last           = last_r;

endmodule

// File: src/knx_frame_field_parser_core.sv
// ----------------------------------------------------------------------------
// knx_frame_field_parser_core
// Telegram field parser: one byte per transfer in, one result per payload
// byte out once the end byte of a frame has arrived.
// first result of a frame follows its end byte transfer, via the queue push,
//   then the emitter issue, when the emitter is idle
// throughput: input one byte per cycle unless stalled; results one per cycle
//   unless out_stall, length+1 per frame, from the double-banked payload store
// input stalls while two completed frames still wait to be emitted
// reset: synchronous active-low rst_n clears parser stage, queue and output
// valid; payload store and data registers are not reset
// ----------------------------------------------------------------------------
module knx_frame_field_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_clear_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_repeat_flag,
  output logic [1:0]  out_priority_res,
  output logic [15:0] out_source_address,
  output logic [15:0] out_target_address,
  output logic        out_group_target,
  output logic [2:0]  out_hop_count,
  output logic [4:0]  out_payload_count,
  output logic [3:0]  out_payload_index,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_check_byte,
  output logic [7:0]  out_end_byte,
  output logic        out_last
);
  import knxfp_pkg::*;

  ram_wr_t           ram_wr;
  push_t             push;
  desc_t             head;
  qstat_t            stat;
  logic              pop;
  logic              ram_re;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  assign in_stall = stat.full;

  knxfp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_valid && !in_stall),
    .rx_byte     (in_rx_byte),
    .clear_frame (in_clear_frame),
    .ram_wr      (ram_wr),
    .push        (push)
  );

  knxfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  knxfp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  knxfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .stat               (stat),
    .pop                (pop),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_repeat_flag    (out_repeat_flag),
    .out_priority_res   (out_priority_res),
    .out_source_address (out_source_address),
    .out_target_address (out_target_address),
    .out_group_target   (out_group_target),
    .out_hop_count      (out_hop_count),
    .out_payload_count  (out_payload_count),
    .out_payload_index  (out_payload_index),
    .out_payload_byte   (out_payload_byte),
    .out_check_byte     (out_check_byte),
    .out_end_byte       (out_end_byte),
    .out_last           (out_last)
  );

endmodule
